// ----- rtl/touch_panel_position_reader_unit_macros.svh -----
// assertion macros shared by the touch panel position reader modules
`ifndef TOUCH_PANEL_POSITION_READER_UNIT_MACROS_SVH
`define TOUCH_PANEL_POSITION_READER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// holds at every clock edge out of reset
`define TPRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen out of reset
`define TPRD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TPRD_ASSERT(lbl, prop, msg)
`define TPRD_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/tprd_pkg.sv -----
// shared constants and types of the touch panel position reader
package tprd_pkg;

  localparam int CMD_BITS      = 8;
  localparam int READ_BITS     = 16;
  localparam int RAW_BITS      = 12;
  localparam int TICK_W        = 16;
  localparam int CNT_W         = 5;
  localparam int GAIN_W        = 24;
  localparam int OFFS_W        = 32;
  localparam int PROD_W        = 36;
  localparam int SUM_W         = 37;
  localparam int N_LSB         = 6;
  localparam int N_W           = 23;
  localparam int RECIP_W       = 24;
  localparam int RECIP_SHIFT   = 37;
  localparam int QUOT_W        = 10;
  localparam int POS_X_W       = 8;
  localparam int POS_Y_W       = 9;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int SCALE         = 1000000;
  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 320;

  // ceil(2^37 / 15625); 1e6 = 64 * 15625, the 64 is taken by dropping six bits
  localparam logic [RECIP_W-1:0] RECIP = 24'd8796094;

  localparam logic signed [SUM_W-1:0] LOW_BOUND = SUM_W'(-SCALE);
  localparam logic signed [SUM_W-1:0] X_BOUND   = SUM_W'(SCREEN_WIDTH * SCALE);
  localparam logic signed [SUM_W-1:0] Y_BOUND   = SUM_W'(SCREEN_HEIGHT * SCALE);

  localparam logic [CFG_IDX_W-1:0] REG_CMD_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONV_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_X_GAIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN     = 3'd7;

  typedef struct packed {
    logic [CMD_BITS-1:0]      cmd_x;
    logic [CMD_BITS-1:0]      cmd_y;
    logic [TICK_W-1:0]        bit_ticks;
    logic [TICK_W-1:0]        conv_ticks;
    logic signed [OFFS_W-1:0] x_offset;
    logic signed [GAIN_W-1:0] x_gain;
    logic signed [OFFS_W-1:0] y_offset;
    logic signed [GAIN_W-1:0] y_gain;
  } cfg_t;

  typedef struct packed {
    logic sck;
    logic mosi;
    logic cs_n;
    logic pos_valid;
    logic range_reject;
  } pins_t;

  typedef struct packed {
    pins_t               pins;
    logic [POS_X_W-1:0]  pos_x;
    logic [POS_Y_W-1:0]  pos_y;
  } res_t;

endpackage

// ----- rtl/tprd_scale.sv -----
// per-axis calibration: offset add, screen range check and divide by one million
module tprd_scale (
  input  logic                                clk,
  input  logic signed [tprd_pkg::PROD_W-1:0]  prod,
  input  logic signed [tprd_pkg::OFFS_W-1:0]  offset,
  input  logic signed [tprd_pkg::SUM_W-1:0]   upper,
  output logic                                ok,
  output logic [tprd_pkg::QUOT_W-1:0]         quot
);

  localparam int MUL_W = tprd_pkg::N_W + tprd_pkg::RECIP_W;

  logic signed [tprd_pkg::SUM_W-1:0] sum_c;
  logic signed [tprd_pkg::SUM_W-1:0] sum_r;
  logic                              ok_r;
  logic [tprd_pkg::N_W-1:0]          n_c;
  logic [MUL_W-1:0]                  mul_r;

  assign sum_c = tprd_pkg::SUM_W'(prod) + tprd_pkg::SUM_W'(offset);

  // small negative sums truncate to zero
  assign n_c = sum_r[tprd_pkg::SUM_W-1] ? '0 :
               sum_r[tprd_pkg::N_LSB+tprd_pkg::N_W-1:tprd_pkg::N_LSB];

  always_ff @(posedge clk) begin
    sum_r <= sum_c;
    ok_r  <= (sum_c > tprd_pkg::LOW_BOUND) && (sum_c < upper);
    mul_r <= {{tprd_pkg::RECIP_W{1'b0}}, n_c} * {{tprd_pkg::N_W{1'b0}}, tprd_pkg::RECIP};
  end

  assign ok   = ok_r;
  assign quot = mul_r[tprd_pkg::RECIP_SHIFT+tprd_pkg::QUOT_W-1:tprd_pkg::RECIP_SHIFT];

endmodule

// ----- rtl/tprd_seq.sv -----
// tick sequencer: serial transactions, bit timing and running gain product
`include "touch_panel_position_reader_unit_macros.svh"

module tprd_seq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               pen_level,
  input  logic                               miso_bit,
  input  tprd_pkg::cfg_t                     cfg,
  input  logic                               ok_x,
  input  logic                               ok_y,
  output tprd_pkg::pins_t                    pins,
  output logic signed [tprd_pkg::PROD_W-1:0] prod_x,
  output logic signed [tprd_pkg::PROD_W-1:0] prod_y
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_CONV = 3'd2;
  localparam logic [2:0] PH_PLO  = 3'd3;
  localparam logic [2:0] PH_PHI  = 3'd4;
  localparam logic [2:0] PH_READ = 3'd5;
  localparam logic [2:0] PH_REL  = 3'd6;

  localparam int PW = tprd_pkg::PROD_W;
  localparam int GW = tprd_pkg::GAIN_W;
  localparam int TW = tprd_pkg::TICK_W;
  localparam int CW = tprd_pkg::CNT_W;

  logic [2:0]              phase_r, phase_nxt;
  logic [CW-1:0]           bc_r, bc_nxt;
  logic [TW-1:0]           tick_r, tick_nxt;
  logic                    axis_y_r, axis_y_nxt;
  logic [7:0]              cmd_sh_r, cmd_sh_nxt;
  logic                    clk_lvl_r, clk_lvl_nxt;
  logic signed [PW-1:0]    acc_r, acc_nxt;
  logic signed [PW-1:0]    held_x_r, held_x_nxt;

  logic [TW-1:0]           low_len;
  logic [TW:0]             tick_inc;
  logic [CW-1:0]           bc_inc;
  logic signed [GW-1:0]    gain_sel;
  logic signed [PW-1:0]    gain_ext;
  tprd_pkg::pins_t         pins_c;

  assign low_len  = (cfg.bit_ticks == '0) ? TW'(1) : cfg.bit_ticks;
  assign tick_inc = {1'b0, tick_r} + (TW+1)'(1);
  assign bc_inc   = bc_r + CW'(1);
  assign gain_sel = axis_y_r ? cfg.y_gain : cfg.x_gain;
  assign gain_ext = {{(PW-GW){gain_sel[GW-1]}}, gain_sel};

  always_comb begin
    phase_nxt   = phase_r;
    bc_nxt      = bc_r;
    tick_nxt    = tick_r;
    axis_y_nxt  = axis_y_r;
    cmd_sh_nxt  = cmd_sh_r;
    clk_lvl_nxt = clk_lvl_r;
    acc_nxt     = acc_r;
    held_x_nxt  = held_x_r;
    pins_c      = '0;
    case (phase_r)
      PH_CMD: begin
        pins_c.mosi = cmd_sh_r[7];
        if (tick_r < low_len) begin
          clk_lvl_nxt = 1'b0;
          tick_nxt    = tick_inc[TW-1:0];
        end else begin
          clk_lvl_nxt = 1'b1;
          tick_nxt    = '0;
          cmd_sh_nxt  = {cmd_sh_r[6:0], 1'b0};
          bc_nxt      = bc_inc;
          if (bc_inc >= CW'(tprd_pkg::CMD_BITS)) begin
            bc_nxt    = '0;
            phase_nxt = (cfg.conv_ticks == '0) ? PH_PLO : PH_CONV;
          end
        end
      end
      PH_CONV: begin
        clk_lvl_nxt = 1'b1;
        tick_nxt    = tick_inc[TW-1:0];
        if (tick_inc >= {1'b0, cfg.conv_ticks}) begin
          tick_nxt  = '0;
          phase_nxt = PH_PLO;
        end
      end
      PH_PLO, PH_PHI: begin
        clk_lvl_nxt = (phase_r == PH_PHI);
        tick_nxt    = tick_inc[TW-1:0];
        if (tick_inc >= {1'b0, low_len}) begin
          tick_nxt = '0;
          if (phase_r == PH_PLO) begin
            phase_nxt = PH_PHI;
          end else begin
            phase_nxt = PH_READ;
            bc_nxt    = '0;
            acc_nxt   = '0;
          end
        end
      end
      PH_READ: begin
        if (tick_r < low_len) begin
          clk_lvl_nxt = 1'b0;
          tick_nxt    = tick_inc[TW-1:0];
        end else begin
          clk_lvl_nxt = 1'b1;
          tick_nxt    = '0;
          // only the leading raw bits weigh in; gain*raw builds up msb first
          if (bc_r < CW'(tprd_pkg::RAW_BITS)) begin
            acc_nxt = {acc_r[PW-2:0], 1'b0} + (miso_bit ? gain_ext : '0);
          end
          bc_nxt = bc_inc;
          if (bc_inc >= CW'(tprd_pkg::READ_BITS)) begin
            bc_nxt = '0;
            if (!axis_y_r) begin
              held_x_nxt = acc_nxt;
              axis_y_nxt = 1'b1;
              phase_nxt  = PH_CMD;
              cmd_sh_nxt = cfg.cmd_y;
              tick_nxt   = '0;
            end else begin
              axis_y_nxt = 1'b0;
              if (ok_x && ok_y) begin
                pins_c.pos_valid = 1'b1;
                phase_nxt        = PH_REL;
              end else begin
                pins_c.range_reject = 1'b1;
                phase_nxt           = PH_IDLE;
              end
            end
          end
        end
      end
      PH_REL: begin
        pins_c.cs_n = 1'b1;
        if (pen_level) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        pins_c.cs_n = 1'b1;
        phase_nxt   = PH_IDLE;
        if (!pen_level) begin
          axis_y_nxt = 1'b0;
          phase_nxt  = PH_CMD;
          cmd_sh_nxt = cfg.cmd_x;
          bc_nxt     = '0;
          tick_nxt   = '0;
        end
      end
    endcase
    pins_c.sck = clk_lvl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bc_r      <= '0;
      tick_r    <= '0;
      axis_y_r  <= 1'b0;
      cmd_sh_r  <= '0;
      clk_lvl_r <= 1'b0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      bc_r      <= bc_nxt;
      tick_r    <= tick_nxt;
      axis_y_r  <= axis_y_nxt;
      cmd_sh_r  <= cmd_sh_nxt;
      clk_lvl_r <= clk_lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r    <= acc_nxt;
      held_x_r <= held_x_nxt;
    end
  end

  assign pins   = pins_c;
  assign prod_x = held_x_r;
  assign prod_y = acc_r;

  `TPRD_ASSERT(a_cmd_count, (phase_r == PH_CMD) |-> (bc_r < CW'(tprd_pkg::CMD_BITS)), "command bit count overrun")
  `TPRD_ASSERT(a_valid_to_rel, (adv && pins_c.pos_valid) |=> (phase_r == PH_REL), "accepted position not followed by release wait")
  `TPRD_ASSERT(a_reject_to_idle, (adv && pins_c.range_reject) |=> (phase_r == PH_IDLE && !axis_y_r), "rejected attempt not back in idle")
  `TPRD_NEVER(n_cs_outside, pins_c.cs_n && phase_r != PH_IDLE && phase_r != PH_REL, "chip select high inside a transaction")

endmodule

// ----- rtl/touch_panel_position_reader_unit.sv -----
// Touch panel position reader: one input item is one timebase tick (pen level and serial
// data in) and gives exactly one result item (serial pin levels and, when an attempt ends,
// the calibrated position or a range reject). An item is taken every clock cycle while
// in_ready is high; its result is registered in the output register, or in the one-entry
// skid stage behind it while output stalls; in_ready drops only while two results wait.
// The calibration product is built up one data bit per sample tick, and the offset add,
// range check and divide by one million run in two registered steps behind it, well ahead
// of the final sample tick. Configuration writes are taken every cycle.
`include "touch_panel_position_reader_unit_macros.svh"

module touch_panel_position_reader_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_pen_level,
  input  logic                                 in_miso_bit,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_sck,
  output logic                                 out_mosi,
  output logic                                 out_cs_n,
  output logic                                 out_pos_valid,
  output logic [tprd_pkg::POS_X_W-1:0]         out_pos_x,
  output logic [tprd_pkg::POS_Y_W-1:0]         out_pos_y,
  output logic                                 out_range_reject,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tprd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tprd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  tprd_pkg::cfg_t                     cfg_r;
  tprd_pkg::pins_t                    pins;
  tprd_pkg::res_t                     res_c;
  tprd_pkg::res_t                     out_r, out_nxt;
  tprd_pkg::res_t                     skid_r, skid_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               skid_valid_r, skid_valid_nxt;
  logic                               accept;
  logic                               take;
  logic                               ok_x, ok_y;
  logic [tprd_pkg::QUOT_W-1:0]        quot_x, quot_y;
  logic signed [tprd_pkg::PROD_W-1:0] prod_x, prod_y;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign take      = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cmd_x      <= 8'd144;
      cfg_r.cmd_y      <= 8'd208;
      cfg_r.bit_ticks  <= 16'd1;
      cfg_r.conv_ticks <= 16'd6;
      cfg_r.x_offset   <= 32'sd255169000;
      cfg_r.x_gain     <= -24'sd64294;
      cfg_r.y_offset   <= -32'sd18023900;
      cfg_r.y_gain     <= 24'sd89830;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tprd_pkg::REG_CMD_X:      cfg_r.cmd_x      <= cfg_data[7:0];
        tprd_pkg::REG_CMD_Y:      cfg_r.cmd_y      <= cfg_data[7:0];
        tprd_pkg::REG_BIT_TICKS:  cfg_r.bit_ticks  <= cfg_data[15:0];
        tprd_pkg::REG_CONV_TICKS: cfg_r.conv_ticks <= cfg_data[15:0];
        tprd_pkg::REG_X_OFFSET:   cfg_r.x_offset   <= cfg_data;
        tprd_pkg::REG_X_GAIN:     cfg_r.x_gain     <= cfg_data[23:0];
        tprd_pkg::REG_Y_OFFSET:   cfg_r.y_offset   <= cfg_data;
        tprd_pkg::REG_Y_GAIN:     cfg_r.y_gain     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  tprd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (accept),
    .pen_level (in_pen_level),
    .miso_bit  (in_miso_bit),
    .cfg       (cfg_r),
    .ok_x      (ok_x),
    .ok_y      (ok_y),
    .pins      (pins),
    .prod_x    (prod_x),
    .prod_y    (prod_y)
  );

  tprd_scale u_scale_x (
    .clk    (clk),
    .prod   (prod_x),
    .offset (cfg_r.x_offset),
    .upper  (tprd_pkg::X_BOUND),
    .ok     (ok_x),
    .quot   (quot_x)
  );

  tprd_scale u_scale_y (
    .clk    (clk),
    .prod   (prod_y),
    .offset (cfg_r.y_offset),
    .upper  (tprd_pkg::Y_BOUND),
    .ok     (ok_y),
    .quot   (quot_y)
  );

  always_comb begin
    res_c.pins  = pins;
    res_c.pos_x = pins.pos_valid ? quot_x[tprd_pkg::POS_X_W-1:0] : '0;
    res_c.pos_y = pins.pos_valid ? quot_y[tprd_pkg::POS_Y_W-1:0] : '0;
  end

  // output register with a one-entry skid behind it
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res_c;
        out_valid_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt       = res_c;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sck          = out_r.pins.sck;
  assign out_mosi         = out_r.pins.mosi;
  assign out_cs_n         = out_r.pins.cs_n;
  assign out_pos_valid    = out_r.pins.pos_valid;
  assign out_pos_x        = out_r.pos_x;
  assign out_pos_y        = out_r.pos_y;
  assign out_range_reject = out_r.pins.range_reject;

  `TPRD_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid holds an item while output is empty")
  `TPRD_ASSERT(a_skid_fill, $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready), "skid filled without a stalled output")
  `TPRD_NEVER(n_both_flags, res_c.pins.pos_valid && res_c.pins.range_reject, "position and reject in one item")

endmodule
